>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/uvd_pkg.sv
// ----------------------------------------------------------------------------
// uvd_pkg
// Types, codes and byte classification shared by the path decoder core.
// ----------------------------------------------------------------------------
package uvd_pkg;

    localparam int unsigned LEN_W       = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd2048;
    localparam logic [LEN_W-1:0] CNT_MAX       = 16'hFFFF;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] BYTE_MIN = 8'd32;
    localparam logic [7:0] BYTE_MAX = 8'd126;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    localparam logic [1:0] SEG_EMPTY  = 2'd0;
    localparam logic [1:0] SEG_DOT    = 2'd1;
    localparam logic [1:0] SEG_DOTDOT = 2'd2;
    localparam logic [1:0] SEG_OTHER  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic [7:0] raw;
        logic       last;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_pct;
        logic       is_allowed;
        logic       is_slash;
        logic       is_dot;
        logic       is_hash;
    } t_cls;

    function automatic logic allowed_raw(input logic [7:0] b);
        logic ok;
        case (b) inside
            ["A":"Z"], ["a":"z"], ["0":"9"],
            "-", ".", "_", "~", ":", "/", "?", "#", "[", "]", "@",
            "!", "$", "&", "'", "(", ")", "*", "+", ",", ";", "=": ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        case (b) inside
            ["0":"9"]: r = {1'b1, 4'(b - 8'h30)};
            ["A":"F"]: r = {1'b1, 4'(b - 8'h37)};
            ["a":"f"]: r = {1'b1, 4'(b - 8'h57)};
            default:   r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/uvd_front.sv
// ----------------------------------------------------------------------------
// uvd_front
// Input stage: accepts raw path bytes and registers their classification.
// ----------------------------------------------------------------------------
module uvd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  uvd_pkg::t_in_item i_in_data,
    output logic              o_cls_valid,
    input  logic              i_cls_ready,
    output uvd_pkg::t_cls     o_cls_data
);

    logic          r_valid;
    uvd_pkg::t_cls r_cls;
    uvd_pkg::t_cls n_cls;
    logic [4:0]    hex;

    assign o_in_ready  = !r_valid || i_cls_ready;
    assign o_cls_valid = r_valid;
    assign o_cls_data  = r_cls;

    always_comb begin
        hex              = uvd_pkg::hex_decode(i_in_data.in_byte);
        n_cls.raw        = i_in_data.in_byte;
        n_cls.last       = i_in_data.last;
        n_cls.is_hex     = hex[4];
        n_cls.hex_val    = hex[3:0];
        n_cls.is_pct     = (i_in_data.in_byte == uvd_pkg::CH_PCT);
        n_cls.is_allowed = uvd_pkg::allowed_raw(i_in_data.in_byte);
        n_cls.is_slash   = (i_in_data.in_byte == uvd_pkg::CH_SLASH);
        n_cls.is_dot     = (i_in_data.in_byte == uvd_pkg::CH_DOT);
        n_cls.is_hash    = (i_in_data.in_byte == uvd_pkg::CH_HASH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_cls <= n_cls;
        end
    end

endmodule

>>> rtl/core/uvd_queue.sv
// ----------------------------------------------------------------------------
// uvd_queue
// Short FIFO of classified bytes between the front and back stages.
// ----------------------------------------------------------------------------
module uvd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  uvd_pkg::t_cls i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output uvd_pkg::t_cls o_data
);

    uvd_pkg::t_cls             r_mem [uvd_pkg::QUEUE_DEPTH];
    logic [uvd_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [uvd_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [uvd_pkg::QPTR_W:0]   r_count;
    logic                       push;
    logic                       pop;

    assign o_ready = (r_count != (uvd_pkg::QPTR_W+1)'(uvd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/core/uvd_back.sv
// ----------------------------------------------------------------------------
// uvd_back
// Path state tracking, percent decoding and result register.
// ----------------------------------------------------------------------------
module uvd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cls_valid,
    output logic                      o_cls_ready,
    input  uvd_pkg::t_cls             i_cls_data,
    input  logic [uvd_pkg::LEN_W-1:0] i_max_length,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output uvd_pkg::t_out_item        o_out_data
);

    logic                      r_at_start, n_at_start;
    logic                      r_first_bad, n_first_bad;
    logic                      r_error_seen, n_error_seen;
    logic                      r_hash_seen, n_hash_seen;
    logic [1:0]                r_esc, n_esc;
    logic [3:0]                r_high, n_high;
    logic [uvd_pkg::LEN_W-1:0] r_count, n_count;
    logic [1:0]                r_seg, n_seg;
    logic                      r_out_valid, n_out_valid;
    uvd_pkg::t_out_item        r_out_data, n_out_data;

    logic       have;
    logic [7:0] ob;
    logic [7:0] dec;
    logic       too_long;
    logic       emit;
    logic       pop;

    assign o_cls_ready = !r_out_valid || i_out_ready;
    assign pop         = i_cls_valid && o_cls_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_at_start   = r_at_start;
        n_first_bad  = r_first_bad;
        n_error_seen = r_error_seen;
        n_hash_seen  = r_hash_seen;
        n_esc        = r_esc;
        n_high       = r_high;
        n_count      = r_count;
        n_seg        = r_seg;
        have         = 1'b0;
        ob           = 8'd0;
        dec          = {r_high, i_cls_data.hex_val};

        if (r_count != uvd_pkg::CNT_MAX) begin
            n_count = r_count + 1'b1;
        end
        if (r_at_start) begin
            if (!i_cls_data.is_slash) begin
                n_first_bad = 1'b1;
            end
            n_at_start = 1'b0;
        end

        unique case (r_esc)
            uvd_pkg::ESC_HIGH: begin
                if (i_cls_data.is_hex) begin
                    n_high = i_cls_data.hex_val;
                    n_esc  = uvd_pkg::ESC_LOW;
                end else begin
                    n_error_seen = 1'b1;
                    n_esc        = uvd_pkg::ESC_NONE;
                end
                n_seg = uvd_pkg::SEG_OTHER;
            end
            uvd_pkg::ESC_LOW: begin
                if (i_cls_data.is_hex && dec >= uvd_pkg::BYTE_MIN
                        && dec <= uvd_pkg::BYTE_MAX) begin
                    have = 1'b1;
                    ob   = dec;
                end else begin
                    n_error_seen = 1'b1;
                end
                n_esc = uvd_pkg::ESC_NONE;
                n_seg = uvd_pkg::SEG_OTHER;
            end
            default: begin
                if (i_cls_data.is_pct) begin
                    if (r_hash_seen) begin
                        n_error_seen = 1'b1;
                    end else begin
                        n_esc = uvd_pkg::ESC_HIGH;
                    end
                    n_seg = uvd_pkg::SEG_OTHER;
                end else if (!i_cls_data.is_allowed) begin
                    n_error_seen = 1'b1;
                    n_seg        = uvd_pkg::SEG_OTHER;
                end else begin
                    if (i_cls_data.is_hash) begin
                        n_hash_seen = 1'b1;
                    end
                    if (i_cls_data.is_slash) begin
                        if (r_seg inside {uvd_pkg::SEG_DOT, uvd_pkg::SEG_DOTDOT}) begin
                            n_error_seen = 1'b1;
                        end
                        n_seg = uvd_pkg::SEG_EMPTY;
                    end else if (i_cls_data.is_dot) begin
                        if (r_seg != uvd_pkg::SEG_OTHER) begin
                            n_seg = r_seg + 1'b1;
                        end
                    end else begin
                        n_seg = uvd_pkg::SEG_OTHER;
                    end
                    have = 1'b1;
                    ob   = i_cls_data.raw;
                end
            end
        endcase

        if (i_cls_data.last) begin
            if (n_esc != uvd_pkg::ESC_NONE) begin
                n_error_seen = 1'b1;
            end
            if (n_seg inside {uvd_pkg::SEG_DOT, uvd_pkg::SEG_DOTDOT}) begin
                n_error_seen = 1'b1;
            end
        end

        too_long = (n_count > i_max_length);
        emit     = have && !n_error_seen && !n_first_bad && !too_long;

        n_out_data.out_byte   = emit ? ob : 8'd0;
        n_out_data.byte_valid = emit;
        n_out_data.done_res   = i_cls_data.last;
        if (!i_cls_data.last) begin
            n_out_data.status = uvd_pkg::ST_OK;
        end else if (n_first_bad) begin
            n_out_data.status = uvd_pkg::ST_BAD;
        end else if (too_long) begin
            n_out_data.status = uvd_pkg::ST_LONG;
        end else if (n_error_seen) begin
            n_out_data.status = uvd_pkg::ST_BAD;
        end else begin
            n_out_data.status = uvd_pkg::ST_OK;
        end

        n_out_valid = r_out_valid && !i_out_ready;
        if (pop) begin
            n_out_valid = emit || i_cls_data.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start   <= 1'b1;
            r_first_bad  <= 1'b0;
            r_error_seen <= 1'b0;
            r_hash_seen  <= 1'b0;
            r_esc        <= uvd_pkg::ESC_NONE;
            r_high       <= 4'd0;
            r_count      <= '0;
            r_seg        <= uvd_pkg::SEG_EMPTY;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (pop) begin
                if (i_cls_data.last) begin
                    r_at_start   <= 1'b1;
                    r_first_bad  <= 1'b0;
                    r_error_seen <= 1'b0;
                    r_hash_seen  <= 1'b0;
                    r_esc        <= uvd_pkg::ESC_NONE;
                    r_high       <= 4'd0;
                    r_count      <= '0;
                    r_seg        <= uvd_pkg::SEG_EMPTY;
                end else begin
                    r_at_start   <= n_at_start;
                    r_first_bad  <= n_first_bad;
                    r_error_seen <= n_error_seen;
                    r_hash_seen  <= n_hash_seen;
                    r_esc        <= n_esc;
                    r_high       <= n_high;
                    r_count      <= n_count;
                    r_seg        <= n_seg;
                end
            end
        end
        if (pop) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

>>> rtl/core/uri_path_validate_decode_core.sv
// ----------------------------------------------------------------------------
// uri_path_validate_decode_core
// Streaming request path validator and percent decoder.
// ----------------------------------------------------------------------------
// Input channel (i_in_*): one raw path byte per beat, last set on the final
// byte. Output channel (o_out_*): one beat per emitted decoded byte, and one
// beat for the final byte that carries done_res and status (ok, bad, too long).
// Bytes that are consumed by an escape or follow an error give no beat.
// Config channel (i_cfg_*): writes max_length; always ready. The user must
// keep it written between paths only; the block does not enforce this.
// Throughput is one byte per cycle while the receiver keeps accepting beats.
// An input beat passes through the front classification register, the queue
// and the back result register before it reaches the output channel.
// A stalled receiver holds the result register; the 4-entry queue and the
// front register absorb up to 5 more bytes before o_in_ready drops.
// Synchronous reset clears path state and the queue, and sets max_length to
// 2048. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uri_path_validate_decode_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  uvd_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output uvd_pkg::t_out_item        o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [uvd_pkg::LEN_W-1:0] i_cfg_data
);

    logic [uvd_pkg::LEN_W-1:0] r_max_length;
    logic                      f_valid, f_ready;
    uvd_pkg::t_cls             f_data;
    logic                      q_valid, q_ready;
    uvd_pkg::t_cls             q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= uvd_pkg::MAX_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_length <= i_cfg_data;
        end
    end

    uvd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cls_valid (f_valid),
        .i_cls_ready (f_ready),
        .o_cls_data  (f_data)
    );

    uvd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    uvd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cls_valid  (q_valid),
        .o_cls_ready  (q_ready),
        .i_cls_data   (q_data),
        .i_max_length (r_max_length),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    `ASSERT_IMPL(a_idle_beat_is_done, i_clk, i_rst_n, o_out_valid && !o_out_data.byte_valid, o_out_data.done_res, "result beat without byte or done")
    `ASSERT_IMPL(a_status_only_done, i_clk, i_rst_n, o_out_valid && !o_out_data.done_res, o_out_data.status == uvd_pkg::ST_OK, "status set on non-final beat")
    `ASSERT_IMPL(a_no_byte_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.byte_valid, o_out_data.out_byte == 8'd0, "out_byte nonzero without byte_valid")
    `ASSERT_NEXT(a_cfg_write, i_clk, i_rst_n, i_cfg_valid && i_rst_n, r_max_length == $past(i_cfg_data), "max_length not written")

endmodule
